### src/sdnt_pkg.sv
package sdnt_pkg;

   localparam int FIELD_W = 40;
   localparam int TARGET_W = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int PRIME_SLOTS = 8;
   localparam int PRIME_W = 5;
   localparam int DEF_VALUE_BITS = 40;
   localparam int DEF_NUM_PRIMES = 8;

   localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   localparam logic REG_MIN_COFACTOR = 1'b0;
   localparam logic REG_NTT_MODE = 1'b1;

   typedef struct packed {
      logic load;
      logic fact_start;
      logic fact_accept;
      logic fact_next;
      logic cand_start;
      logic cand_take;
      logic step;
      logic res_bad;
      logic res_final;
   } cmd_type;

   typedef struct packed {
      logic phi_bad;
      logic div_done;
      logic rem_zero;
      logic pidx_last;
      logic cof_one;
      logic cand_better;
      logic quot_ok;
      logic odo_last;
   } sts_type;

   function automatic logic [PRIME_W-1:0] prime_of(input logic [2:0] idx);
      logic [PRIME_W-1:0] p;
      unique case (idx)
         3'd0: p = 5'd2;
         3'd1: p = 5'd3;
         3'd2: p = 5'd5;
         3'd3: p = 5'd7;
         3'd4: p = 5'd11;
         3'd5: p = 5'd13;
         3'd6: p = 5'd17;
         default: p = 5'd19;
      endcase
      return p;
   endfunction

endpackage

### src/smooth_divisor_nearest_target_top.sv
// Finds the even divisor of phi_value nearest target_size, subject to the quotient floor
// min_cofactor and, in NTT mode, staying below the target; one word in, one word out, one word
// at a time. Factoring divides phi_value/2 by each prime in turn, as often as it divides; then
// every even divisor is walked, with a quotient division for each divisor that improves on the
// best so far. A single bit-serial divider is shared by factoring and the quotient check. A zero
// or odd value is answered from the check state, before factoring starts; a value that is not
// smooth answers once factoring ends. The result word is held until taken.
module smooth_divisor_nearest_target_top #(
   parameter int VALUE_BITS = sdnt_pkg::DEF_VALUE_BITS,
   parameter int NUM_PRIMES = sdnt_pkg::DEF_NUM_PRIMES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sdnt_pkg::FIELD_W-1:0]          req_phi_value,
   input  logic [sdnt_pkg::TARGET_W-1:0]         req_target_size,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sdnt_pkg::FIELD_W-1:0]          rsp_chosen_divisor,
   output logic [sdnt_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sdnt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sdnt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sdnt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import sdnt_pkg::*;

   localparam int VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;

   logic [VW-1:0] min_cof_ff;
   logic ntt_ff;
   logic csr_wr;
   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cof_ff <= '0;
         ntt_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3])
            REG_MIN_COFACTOR: min_cof_ff <= csr_pwdata[VW-1:0];
            REG_NTT_MODE: ntt_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_MIN_COFACTOR: csr_prdata = CSR_DATA_W'(min_cof_ff);
         REG_NTT_MODE: csr_prdata = CSR_DATA_W'(ntt_ff);
         default: csr_prdata = '0;
      endcase
   end

   sdnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   sdnt_dp #(.VW(VW), .NUM_PRIMES(NUM_PRIMES)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .phi_value      (req_phi_value),
      .target_size    (req_target_size),
      .min_cofactor   (min_cof_ff),
      .ntt_mode       (ntt_ff),
      .chosen_divisor (rsp_chosen_divisor),
      .status         (rsp_status)
   );
endmodule

### src/sdnt_div.sv
module sdnt_div #(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0] quot_ff, quot_in;
   logic [W:0] rem_ff, rem_in;
   logic [W-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W:0] rem_sh;
   logic [W:0] diff;

   always_comb begin
      rem_sh = {rem_ff[W-1:0], quot_ff[W-1]};
      diff = rem_sh - {1'b0, dsr_ff};
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[W]) begin
            rem_in = rem_sh;
            quot_in = {quot_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff;
            quot_in = {quot_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem = rem_ff[W-1:0];
endmodule

### src/sdnt_dp.sv
module sdnt_dp #(
   parameter int VW = 40,
   parameter int NUM_PRIMES = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sdnt_pkg::cmd_type                     cmd,
   output sdnt_pkg::sts_type                     sts,
   input  logic [sdnt_pkg::FIELD_W-1:0]          phi_value,
   input  logic [sdnt_pkg::TARGET_W-1:0]         target_size,
   input  logic [VW-1:0]                         min_cofactor,
   input  logic                                  ntt_mode,
   output logic [sdnt_pkg::FIELD_W-1:0]          chosen_divisor,
   output logic [sdnt_pkg::STATUS_W-1:0]         status
);
   import sdnt_pkg::*;

   localparam int PW = (NUM_PRIMES > 1) ? $clog2(NUM_PRIMES) : 1;
   localparam int EW = $clog2(VW);
   localparam int DW = (VW > TARGET_W) ? VW : TARGET_W;

   logic [VW-1:0] phi_ff;
   logic [TARGET_W-1:0] tgt_ff;
   logic [VW-1:0] cof_ff;
   logic [VW-1:0] best_ff;
   logic [PW-1:0] pidx_ff;
   logic [EW-1:0] maxe_ff [NUM_PRIMES];
   logic [EW-1:0] cur_ff [NUM_PRIMES];
   logic [VW-1:0] base_ff [NUM_PRIMES];
   logic [FIELD_W-1:0] res_div_ff;
   logic [STATUS_W-1:0] res_sts_ff;

   logic div_start;
   logic [VW-1:0] div_n, div_d, div_q, div_r;
   logic div_done;
   logic [PRIME_W-1:0] cur_prime, step_prime;
   logic sel_found;
   logic [PW-1:0] sel_k;
   logic [VW+PRIME_W-1:0] prod;
   logic [DW-1:0] d_ext, b_ext, t_ext, dist_d, dist_b;

   assign cur_prime = prime_of(3'(pidx_ff));
   assign div_start = cmd.fact_start | cmd.cand_start;
   assign div_n = cmd.cand_start ? phi_ff : cof_ff;
   assign div_d = cmd.cand_start ? base_ff[0] : VW'(cur_prime);

   sdnt_div #(.W(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   always_comb begin
      sel_found = 1'b0;
      sel_k = '0;
      for (int k = 0; k < NUM_PRIMES; k++) begin
         if (!sel_found && cur_ff[k] < maxe_ff[k]) begin
            sel_found = 1'b1;
            sel_k = PW'(k);
         end
      end
   end

   assign step_prime = prime_of(3'(sel_k));
   assign prod = base_ff[sel_k] * step_prime;

   always_comb begin
      d_ext = DW'(base_ff[0]);
      b_ext = DW'(best_ff);
      t_ext = DW'(tgt_ff);
      dist_d = (d_ext > t_ext) ? d_ext - t_ext : t_ext - d_ext;
      dist_b = (b_ext > t_ext) ? b_ext - t_ext : t_ext - b_ext;
   end

   always_comb begin
      sts.phi_bad = (phi_ff == '0) || phi_ff[0];
      sts.div_done = div_done;
      sts.rem_zero = (div_r == '0);
      sts.pidx_last = (pidx_ff == PW'(NUM_PRIMES - 1));
      sts.cof_one = (cof_ff == VW'(1));
      sts.cand_better = (dist_d < dist_b) && (!ntt_mode || d_ext < t_ext);
      sts.quot_ok = (div_q >= min_cofactor);
      sts.odo_last = !sel_found;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         phi_ff <= phi_value[VW-1:0];
         tgt_ff <= target_size;
         cof_ff <= {1'b0, phi_value[VW-1:1]};
         best_ff <= '0;
         pidx_ff <= '0;
         for (int k = 0; k < NUM_PRIMES; k++) begin
            maxe_ff[k] <= '0;
            cur_ff[k] <= '0;
            base_ff[k] <= VW'(2);
         end
      end else begin
         if (cmd.fact_accept) begin
            cof_ff <= div_q;
            maxe_ff[pidx_ff] <= maxe_ff[pidx_ff] + 1'b1;
         end
         if (cmd.fact_next) begin
            pidx_ff <= pidx_ff + 1'b1;
         end
         if (cmd.cand_take) begin
            best_ff <= base_ff[0];
         end
         if (cmd.step) begin
            for (int k = 0; k < NUM_PRIMES; k++) begin
               if (PW'(k) == sel_k) begin
                  cur_ff[k] <= cur_ff[k] + 1'b1;
                  base_ff[k] <= prod[VW-1:0];
               end else if (PW'(k) < sel_k) begin
                  cur_ff[k] <= '0;
                  base_ff[k] <= prod[VW-1:0];
               end
            end
         end
      end
      if (cmd.res_bad) begin
         res_div_ff <= '0;
         res_sts_ff <= STATUS_BAD;
      end else if (cmd.res_final) begin
         res_div_ff <= FIELD_W'(best_ff);
         res_sts_ff <= (best_ff != '0) ? STATUS_FOUND : STATUS_NONE;
      end
   end

   assign chosen_divisor = res_div_ff;
   assign status = res_sts_ff;
endmodule

### src/sdnt_ctrl.sv
module sdnt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sdnt_pkg::cmd_type cmd,
   input  sdnt_pkg::sts_type sts
);
   import sdnt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_FACT,
      S_FWAIT,
      S_FCHK,
      S_EVAL,
      S_CWAIT,
      S_STEP,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.phi_bad) begin
               cmd.res_bad = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_FACT;
            end
         end
         S_FACT: begin
            cmd.fact_start = 1'b1;
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (sts.div_done) begin
               if (sts.rem_zero) begin
                  cmd.fact_accept = 1'b1;
                  state_in = S_FACT;
               end else if (sts.pidx_last) begin
                  state_in = S_FCHK;
               end else begin
                  cmd.fact_next = 1'b1;
                  state_in = S_FACT;
               end
            end
         end
         S_FCHK: begin
            if (sts.cof_one) begin
               state_in = S_EVAL;
            end else begin
               cmd.res_bad = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_EVAL: begin
            if (sts.cand_better) begin
               cmd.cand_start = 1'b1;
               state_in = S_CWAIT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_CWAIT: begin
            if (sts.div_done) begin
               cmd.cand_take = sts.quot_ok;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (sts.odo_last) begin
               cmd.res_final = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.step = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
